[rtl/amsu_pkg.sv]
// shared types, constants and lookup functions of the alignment mismatch scorer
// no dependencies; used by every module of the block but amsu_div by scoped names

package amsu_pkg;

	// fixed point of error probabilities: Q1.FRACTION_BITS, 1.0 is 2^FRACTION_BITS
	localparam int FRACTION_BITS       = 16;
	localparam int PROB_W              = FRACTION_BITS + 1;
	localparam int ESUM_W              = FRACTION_BITS + 2;
	localparam int PROD_W              = 2 * PROB_W;
	localparam int COUNT_WIDTH_DEFAULT = 16;

	// result field widths
	localparam int OUT_COUNT_W = 16;
	localparam int OUT_AVG_W   = 17;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int THRESH_W = 6;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_GAP       = 1'b1;
	localparam logic [THRESH_W-1:0] RESET_THRESHOLD = 6'd0;
	localparam logic RESET_GAP = 1'b1;

	localparam logic [7:0] GAP_CHAR = 8'd45;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DRAIN,
		ST_DIV
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic sums_ready;
		logic div_done;
		logic out_free;
	} dp_status_t;

	// 10^(-q/10) in Q1.16, rounded half up per decade
	function automatic logic [PROB_W-1:0] err_prob(input logic [5:0] q);
		logic [PROB_W-1:0] e;
		case (q)
			6'd0:  e = 17'd65536;
			6'd1:  e = 17'd52057;
			6'd2:  e = 17'd41350;
			6'd3:  e = 17'd32846;
			6'd4:  e = 17'd26090;
			6'd5:  e = 17'd20724;
			6'd6:  e = 17'd16462;
			6'd7:  e = 17'd13076;
			6'd8:  e = 17'd10387;
			6'd9:  e = 17'd8250;
			6'd10: e = 17'd6554;
			6'd11: e = 17'd5206;
			6'd12: e = 17'd4135;
			6'd13: e = 17'd3285;
			6'd14: e = 17'd2609;
			6'd15: e = 17'd2072;
			6'd16: e = 17'd1646;
			6'd17: e = 17'd1308;
			6'd18: e = 17'd1039;
			6'd19: e = 17'd825;
			6'd20: e = 17'd655;
			6'd21: e = 17'd521;
			6'd22: e = 17'd414;
			6'd23: e = 17'd328;
			6'd24: e = 17'd261;
			6'd25: e = 17'd207;
			6'd26: e = 17'd165;
			6'd27: e = 17'd131;
			6'd28: e = 17'd104;
			6'd29: e = 17'd83;
			6'd30: e = 17'd66;
			6'd31: e = 17'd52;
			6'd32: e = 17'd41;
			6'd33: e = 17'd33;
			6'd34: e = 17'd26;
			6'd35: e = 17'd21;
			6'd36: e = 17'd16;
			6'd37: e = 17'd13;
			6'd38: e = 17'd10;
			6'd39: e = 17'd8;
			6'd40: e = 17'd7;
			6'd41: e = 17'd5;
			6'd42: e = 17'd4;
			6'd43: e = 17'd3;
			6'd44: e = 17'd3;
			6'd45: e = 17'd2;
			6'd46: e = 17'd2;
			6'd47: e = 17'd1;
			6'd48: e = 17'd1;
			6'd49: e = 17'd1;
			6'd50: e = 17'd1;
			6'd51: e = 17'd1;
			default: e = 17'd0;
		endcase
		return e;
	endfunction

	// average reported when no column contributed: 10^-(floor(qt/10))
	function automatic logic [PROB_W-1:0] empty_avg(input logic [THRESH_W-1:0] qt);
		logic [PROB_W-1:0] e;
		if (qt < 6'd10) begin
			e = 17'd65536;
		end else if (qt < 6'd20) begin
			e = 17'd6554;
		end else if (qt < 6'd30) begin
			e = 17'd655;
		end else if (qt < 6'd40) begin
			e = 17'd66;
		end else if (qt < 6'd50) begin
			e = 17'd7;
		end else if (qt < 6'd60) begin
			e = 17'd1;
		end else begin
			e = 17'd0;
		end
		return e;
	endfunction

endpackage

[rtl/amsu_div.sv]
// serial restoring divider, one quotient bit per cycle
// no package dependencies; instantiated by amsu_dp

module amsu_div #(
	parameter int DVD_W = 33,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/amsu_dp.sv]
// datapath: column qualification, probability pipeline, accumulators, output register
// uses amsu_pkg (tables, command and status types) and instantiates amsu_div

module amsu_dp #(
	parameter int COUNT_WIDTH = amsu_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  amsu_pkg::dp_cmd_t                      cmd,
	output amsu_pkg::dp_status_t                   st,
	input  logic [amsu_pkg::THRESH_W-1:0]          threshold,
	input  logic                                   count_gaps,
	input  logic [7:0]                             base_first,
	input  logic [7:0]                             base_second,
	input  logic [5:0]                             quality_first,
	input  logic [5:0]                             quality_second,
	input  logic                                   last_column,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [amsu_pkg::OUT_COUNT_W-1:0]       mismatch_count,
	output logic [amsu_pkg::OUT_COUNT_W-1:0]       contributing_columns,
	output logic [amsu_pkg::OUT_AVG_W-1:0]         average_mismatch_prob
);

	localparam int PROB_W = amsu_pkg::PROB_W;
	localparam int ESUM_W = amsu_pkg::ESUM_W;
	localparam int PROD_W = amsu_pkg::PROD_W;
	localparam int T_W    = PROD_W + 3;
	localparam int SUM_W  = COUNT_WIDTH + amsu_pkg::FRACTION_BITS + 1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [T_W-1:0] T_ROUND = T_W'(1) << (amsu_pkg::FRACTION_BITS + 1);

	// column qualification
	logic take_c;
	logic gap_c;
	assign gap_c  = (base_first == amsu_pkg::GAP_CHAR) || (base_second == amsu_pkg::GAP_CHAR);
	assign take_c = (quality_first > threshold) && (quality_second > threshold)
	                && (count_gaps || !gap_c);

	// stage 1: table lookup
	logic              vld_s1, take_s1, diff_s1, last_s1;
	logic [PROB_W-1:0] e1_s1, e2_s1;
	// stage 2: product and sum of error probabilities
	logic              vld_s2, take_s2, diff_s2, last_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ESUM_W-1:0] esum_s2;
	// stage 3: mismatch probability
	logic              vld_s3, take_s3, diff_s3, last_s3;
	logic [ESUM_W-1:0] p_s3;

	logic [T_W-1:0]    scaled;
	logic [ESUM_W-1:0] t_c;
	logic [ESUM_W-1:0] p_c;

	assign scaled = (T_W'(prod_s2) << 2) + T_W'(prod_s2) + T_ROUND;
	assign t_c    = ESUM_W'(scaled >> (amsu_pkg::FRACTION_BITS + 2));
	assign p_c    = (t_c > esum_s2) ? '0 : esum_s2 - t_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		take_s1 <= take_c;
		diff_s1 <= base_first != base_second;
		last_s1 <= last_column;
		e1_s1   <= amsu_pkg::err_prob(quality_first);
		e2_s1   <= amsu_pkg::err_prob(quality_second);

		take_s2 <= take_s1;
		diff_s2 <= diff_s1;
		last_s2 <= last_s1;
		prod_s2 <= e1_s1 * e2_s1;
		esum_s2 <= ESUM_W'(e1_s1) + ESUM_W'(e2_s1);

		take_s3 <= take_s2;
		diff_s3 <= diff_s2;
		last_s3 <= last_s2;
		p_s3    <= p_c;
	end

	// accumulators, cleared when the division of an alignment starts
	logic [COUNT_WIDTH-1:0] mis_q;
	logic [COUNT_WIDTH-1:0] col_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   sums_ready_q;
	logic                   add_c;

	assign add_c = vld_s3 && take_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mis_q        <= '0;
			col_q        <= '0;
			sum_q        <= '0;
			sums_ready_q <= 1'b0;
		end else begin
			sums_ready_q <= vld_s3 && last_s3;
			if (cmd.div_start) begin
				mis_q <= '0;
				col_q <= '0;
				sum_q <= '0;
			end else if (add_c) begin
				if (col_q != COUNT_MAX) begin
					col_q <= col_q + 1'b1;
					sum_q <= sum_q + SUM_W'(p_s3);
				end
				if (diff_s3 && (mis_q != COUNT_MAX)) begin
					mis_q <= mis_q + 1'b1;
				end
			end
		end
	end

	// snapshot of the counts while the divider runs
	logic [COUNT_WIDTH-1:0] mis_hold_q;
	logic [COUNT_WIDTH-1:0] col_hold_q;
	logic [SUM_W-1:0]       quotient;
	logic                   div_done;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			mis_hold_q <= mis_q;
			col_hold_q <= col_q;
		end
	end

	amsu_div #(
		.DVD_W (SUM_W),
		.DVS_W (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (col_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// output register
	logic                              out_valid_q;
	logic [amsu_pkg::OUT_COUNT_W-1:0]  mis_out_q;
	logic [amsu_pkg::OUT_COUNT_W-1:0]  col_out_q;
	logic [amsu_pkg::OUT_AVG_W-1:0]    avg_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mis_out_q <= amsu_pkg::OUT_COUNT_W'(mis_hold_q);
			col_out_q <= amsu_pkg::OUT_COUNT_W'(col_hold_q);
			if (col_hold_q == '0) begin
				avg_out_q <= amsu_pkg::OUT_AVG_W'(amsu_pkg::empty_avg(threshold));
			end else begin
				avg_out_q <= amsu_pkg::OUT_AVG_W'(quotient);
			end
		end
	end

	assign out_valid             = out_valid_q;
	assign mismatch_count        = mis_out_q;
	assign contributing_columns  = col_out_q;
	assign average_mismatch_prob = avg_out_q;

	assign st.sums_ready = sums_ready_q;
	assign st.div_done   = div_done;
	assign st.out_free   = !out_valid_q || !out_stall;

endmodule

[rtl/amsu_ctrl.sv]
// controller: streams columns, drains the pipeline at a last column, sequences the division
// uses amsu_pkg (state enum, command and status types)

module amsu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last_column,
	output logic                 in_stall,
	output amsu_pkg::dp_cmd_t    cmd,
	input  amsu_pkg::dp_status_t st
);

	amsu_pkg::ctrl_state_t state_q;
	amsu_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amsu_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			amsu_pkg::ST_RUN: begin
				if (in_valid && last_column) begin
					state_d = amsu_pkg::ST_DRAIN;
				end
			end
			amsu_pkg::ST_DRAIN: begin
				if (st.sums_ready) begin
					state_d = amsu_pkg::ST_DIV;
				end
			end
			amsu_pkg::ST_DIV: begin
				if (st.div_done && st.out_free) begin
					state_d = amsu_pkg::ST_RUN;
				end
			end
			default: state_d = amsu_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		cmd.accept    = 1'b0;
		cmd.div_start = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			amsu_pkg::ST_RUN: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			amsu_pkg::ST_DRAIN: begin
				cmd.div_start = st.sums_ready;
			end
			amsu_pkg::ST_DIV: begin
				cmd.out_load = st.div_done && st.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[rtl/alignment_mismatch_scorer_unit.sv]
// top level of the alignment mismatch scorer: configuration registers and apb port
// uses amsu_pkg; instantiates amsu_ctrl and amsu_dp

// Scores one pairwise alignment streamed as one column per transaction. A column
// counts when both phred qualities strictly exceed quality_threshold and, with
// count_gap_columns at 0, neither base is a dash. Each counting column adds its
// mismatch probability e1 + e2 - 1.25*e1*e2 (Q1.16 error probabilities from a
// 64-entry table) to a running sum; counting columns whose bases differ are also
// counted. Counters saturate at 2^COUNT_WIDTH - 1 and, once the column counter is
// full, the sum stops growing. The column with last_column set produces one result
// transaction: mismatch count, counting columns and average probability (1.0 is
// 65536), or 10^-(floor(threshold/10)) when nothing counted. Columns are taken one
// per cycle. After a last column the input stalls while the three-stage probability
// pipeline drains, the serial divider produces one quotient bit per cycle and the
// result is loaded into an output register. The result then waits there while the
// next alignment streams in; a second result is held back only if the first has
// still not been taken. Registers sit at byte addresses 0 (quality_threshold) and 4
// (count_gap_columns) and must be written only while no alignment is in progress;
// the block itself does not enforce this. No clearing pass follows reset.

module alignment_mismatch_scorer_unit #(
	parameter int COUNT_WIDTH = amsu_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [amsu_pkg::PADDR_W-1:0]       paddr,
	input  logic [amsu_pkg::PDATA_W-1:0]       pwdata,
	output logic [amsu_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	// column input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         base_first,
	input  logic [7:0]                         base_second,
	input  logic [5:0]                         quality_first,
	input  logic [5:0]                         quality_second,
	input  logic                               last_column,
	// result output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [amsu_pkg::OUT_COUNT_W-1:0]   mismatch_count,
	output logic [amsu_pkg::OUT_COUNT_W-1:0]   contributing_columns,
	output logic [amsu_pkg::OUT_AVG_W-1:0]     average_mismatch_prob
);

	// configuration registers; bit 2 of the address picks the register
	logic [amsu_pkg::THRESH_W-1:0] threshold_q;
	logic                          count_gaps_q;
	logic                          cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= amsu_pkg::RESET_THRESHOLD;
			count_gaps_q <= amsu_pkg::RESET_GAP;
		end else if (cfg_write) begin
			case (paddr[2])
				amsu_pkg::REG_THRESHOLD: threshold_q  <= pwdata[amsu_pkg::THRESH_W-1:0];
				amsu_pkg::REG_GAP:       count_gaps_q <= pwdata[0];
				default:                 threshold_q  <= threshold_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			amsu_pkg::REG_THRESHOLD: prdata = amsu_pkg::PDATA_W'(threshold_q);
			amsu_pkg::REG_GAP:       prdata = amsu_pkg::PDATA_W'(count_gaps_q);
			default:                 prdata = '0;
		endcase
	end

	// controller and datapath talk only through these
	amsu_pkg::dp_cmd_t    cmd;
	amsu_pkg::dp_status_t st;

	amsu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_column (last_column),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.st          (st)
	);

	amsu_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.st                    (st),
		.threshold             (threshold_q),
		.count_gaps            (count_gaps_q),
		.base_first            (base_first),
		.base_second           (base_second),
		.quality_first         (quality_first),
		.quality_second        (quality_second),
		.last_column           (last_column),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.mismatch_count        (mismatch_count),
		.contributing_columns  (contributing_columns),
		.average_mismatch_prob (average_mismatch_prob)
	);

`ifndef SYNTHESIS
	// a last column closes the input until its result is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_column) |=> in_stall)
		else $error("input not stalled after last column transaction");

	// an average never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (average_mismatch_prob <= 17'd65536))
		else $error("average mismatch probability above one");

	// mismatches are a subset of counting columns
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((COUNT_WIDTH > amsu_pkg::OUT_COUNT_W)
		               || (mismatch_count <= contributing_columns)))
		else $error("mismatch count exceeds counting columns");

	// a stalled result stays valid and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mismatch_count)
		&& $stable(contributing_columns) && $stable(average_mismatch_prob)))
		else $error("held result changed while stalled");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// testbench of alignment_mismatch_scorer_unit: directed, threshold, long and random tests
// depends on amsu_pkg and the rtl of the block; holds its own scoring model of the alignment

module tb;

	localparam int PADDR_W       = amsu_pkg::PADDR_W;
	localparam int PDATA_W       = amsu_pkg::PDATA_W;
	localparam int THRESH_W      = amsu_pkg::THRESH_W;
	localparam int OUT_COUNT_W   = amsu_pkg::OUT_COUNT_W;
	localparam int OUT_AVG_W     = amsu_pkg::OUT_AVG_W;
	localparam int PROB_W        = amsu_pkg::PROB_W;
	localparam int FRACTION_BITS = amsu_pkg::FRACTION_BITS;

	// quiet cycles tolerated before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// drain, start and serial division after a last column, with margin
	localparam int SETTLE_CYCLES = 48;
	localparam int COUNT_MAX = 65535;
	// columns per random phase and in the long back to back alignment
	localparam int PHASE_COLUMNS = 220;
	localparam int LONG_COLUMNS = 150;
	localparam longint unsigned SUM_MASK = (64'd1 << 33) - 1;
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = {amsu_pkg::REG_THRESHOLD, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_GAP = {amsu_pkg::REG_GAP, 2'b00};

	// one aligned column as it goes into the block
	typedef struct packed {
		logic [7:0] b1;
		logic [7:0] b2;
		logic [5:0] q1;
		logic [5:0] q2;
		logic       last;
	} column_t;

	// one alignment score as it comes out of the block
	typedef struct packed {
		logic [OUT_COUNT_W-1:0] mismatches;
		logic [OUT_COUNT_W-1:0] columns;
		logic [OUT_AVG_W-1:0]   avg;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] base_first = '0;
	logic [7:0] base_second = '0;
	logic [5:0] quality_first = '0;
	logic [5:0] quality_second = '0;
	logic       last_column = 1'b0;

	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [OUT_COUNT_W-1:0] mismatch_count;
	logic [OUT_COUNT_W-1:0] contributing_columns;
	logic [OUT_AVG_W-1:0]   average_mismatch_prob;

	// scoring model state: register copies and per-alignment accumulators
	logic [THRESH_W-1:0] thr_reg = amsu_pkg::RESET_THRESHOLD;
	logic                gap_reg = amsu_pkg::RESET_GAP;
	int unsigned         mm_tally = 0;
	int unsigned         col_tally = 0;
	longint unsigned     prob_total = 0;

	score_t pending_scores[$];
	int     fail_count = 0;
	int     quiet_cycles = 0;
	bit     idling_on = 1'b1;

	alignment_mismatch_scorer_unit i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.psel                  (psel),
		.penable               (penable),
		.pwrite                (pwrite),
		.paddr                 (paddr),
		.pwdata                (pwdata),
		.prdata                (prdata),
		.pready                (pready),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.base_first            (base_first),
		.base_second           (base_second),
		.quality_first         (quality_first),
		.quality_second        (quality_second),
		.last_column           (last_column),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.mismatch_count        (mismatch_count),
		.contributing_columns  (contributing_columns),
		.average_mismatch_prob (average_mismatch_prob)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- scoring model

	// 10^(-m/10) in Q1.32, m = 0..9
	function automatic longint unsigned mantissa_q32(input int m);
		case (m)
			0: return 64'd4294967296;
			1: return 64'd3411613790;
			2: return 64'd2709941160;
			3: return 64'd2152582777;
			4: return 64'd1709857277;
			5: return 64'd1358187913;
			6: return 64'd1078847007;
			7: return 64'd856958639;
			8: return 64'd680706443;
			default: return 64'd540704347;
		endcase
	endfunction

	// mantissa m scaled down by decade k, into Q1.16 with round half up
	function automatic logic [PROB_W-1:0] decade_scaled(input int m, input int k);
		longint unsigned div;
		int i;
		div = 64'd65536;
		for (i = 0; i < k; i++)
			div = div * 10;
		return PROB_W'((mantissa_q32(m) + div / 2) / div);
	endfunction

	function automatic logic [PROB_W-1:0] phred_error(input logic [5:0] q);
		return decade_scaled(int'(q % 10), int'(q / 10));
	endfunction

	// fold one accepted column into the running score; a last column closes the alignment
	task automatic score_column(input column_t c);
		longint unsigned e1, e2, t, s, p;
		bit take;
		score_t r;
		take = (c.q1 > thr_reg) && (c.q2 > thr_reg);
		if (!gap_reg && (c.b1 == amsu_pkg::GAP_CHAR || c.b2 == amsu_pkg::GAP_CHAR))
			take = 1'b0;
		if (take) begin
			e1 = phred_error(c.q1);
			e2 = phred_error(c.q2);
			// 1.25*e1*e2 rounded half up
			t = (5 * e1 * e2 + (64'd1 << (FRACTION_BITS + 1))) >> (FRACTION_BITS + 2);
			s = e1 + e2;
			p = (t > s) ? 0 : s - t;
			// once the column tally is full the sum freezes too
			if (col_tally < COUNT_MAX) begin
				col_tally++;
				prob_total = (prob_total + p) & SUM_MASK;
			end
			if (c.b1 != c.b2 && mm_tally < COUNT_MAX)
				mm_tally++;
		end
		if (c.last) begin
			r.mismatches = mm_tally[OUT_COUNT_W-1:0];
			r.columns = col_tally[OUT_COUNT_W-1:0];
			if (col_tally > 0)
				r.avg = OUT_AVG_W'(prob_total / col_tally);
			else
				r.avg = decade_scaled(0, int'(thr_reg / 10));
			pending_scores.push_back(r);
			mm_tally = 0;
			col_tally = 0;
			prob_total = 0;
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input longint want, input longint got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// each result transaction against the oldest outstanding score
	always @(posedge clk) begin : result_check
		score_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				report_mismatch("unexpected result, mismatch_count", -1, mismatch_count);
			end else begin
				want = pending_scores.pop_front();
				if (mismatch_count !== want.mismatches)
					report_mismatch("mismatch_count", want.mismatches, mismatch_count);
				if (contributing_columns !== want.columns)
					report_mismatch("contributing_columns", want.columns,
						contributing_columns);
				if (average_mismatch_prob !== want.avg)
					report_mismatch("average_mismatch_prob", want.avg,
						average_mismatch_prob);
			end
		end
	end

	// hang detection: any transaction on any port counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL alignment_mismatch_scorer_unit");
				$finish;
			end
		end
	end

	// receiver back-pressure, random when idling is on
	always @(negedge clk) begin
		out_stall <= idling_on && ($urandom_range(99) < 29);
	end

	// ---------------------------------------------------------------- drivers

	// called and returns at a falling edge; valid stays high for a following transaction
	task automatic send_column(input column_t c);
		while (idling_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		base_first <= c.b1;
		base_second <= c.b2;
		quality_first <= c.q1;
		quality_second <= c.q2;
		last_column <= c.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		score_column(c);
		@(negedge clk);
	endtask

	// let every outstanding score arrive and the divider settle before touching registers
	task automatic drain_scores();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// apb write then read back; upper bits of pwdata carry junk the register must drop
	task automatic apb_write_check(input logic [PADDR_W-1:0] addr, input logic [31:0] data,
			input logic [31:0] kept);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== kept)
			report_mismatch("register readback", kept, got);
	endtask

	task automatic configure(input logic [THRESH_W-1:0] thr, input logic gap);
		logic [31:0] junk;
		drain_scores();
		junk = $urandom;
		apb_write_check(ADDR_THRESHOLD, {junk[31:THRESH_W], thr}, 32'(thr));
		thr_reg = thr;
		junk = $urandom;
		apb_write_check(ADDR_GAP, {junk[31:1], gap}, 32'(gap));
		gap_reg = gap;
	endtask

	function automatic column_t make_column(input logic [7:0] b1, input logic [7:0] b2,
			input logic [5:0] q1, input logic [5:0] q2, input logic last);
		column_t c;
		c.b1 = b1;
		c.b2 = b2;
		c.q1 = q1;
		c.q2 = q2;
		c.last = last;
		return c;
	endfunction

	function automatic logic [7:0] random_base();
		case ($urandom_range(9))
			0, 1: return "A";
			2, 3: return "C";
			4, 5: return "G";
			6, 7: return "T";
			8: return amsu_pkg::GAP_CHAR;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly above the threshold so that columns contribute
	function automatic logic [5:0] random_quality();
		int lo;
		lo = (thr_reg < 63) ? thr_reg + 1 : 63;
		if ($urandom_range(99) < 75)
			return 6'($urandom_range(63, lo));
		return 6'($urandom_range(63));
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed_columns();
		configure(0, 1);
		// quality 0 never passes a strict threshold of 0: empty alignment, average 1.0
		send_column(make_column("A", "A", 0, 0, 1));
		// extremes of bases and top quality, whose error rounds to zero
		send_column(make_column(8'd0, 8'd255, 63, 63, 0));
		send_column(make_column(8'd255, 8'd255, 1, 1, 0));
		// gap columns count while count_gap_columns is set
		send_column(make_column(amsu_pkg::GAP_CHAR, "C", 40, 40, 0));
		send_column(make_column(amsu_pkg::GAP_CHAR, amsu_pkg::GAP_CHAR, 30, 1, 1));
		// gap columns skipped on either side
		configure(0, 0);
		send_column(make_column(amsu_pkg::GAP_CHAR, "G", 40, 40, 0));
		send_column(make_column("T", amsu_pkg::GAP_CHAR, 2, 50, 0));
		send_column(make_column("A", "C", 20, 30, 1));
	endtask

	// empty alignments at every decade edge of the threshold, quality just at and above it
	task automatic test_threshold_sweep();
		int sweep[13] = '{9, 10, 19, 20, 29, 30, 39, 40, 49, 50, 59, 60, 63};
		int i;
		logic [5:0] above;
		for (i = 0; i < 13; i++) begin
			configure(6'(sweep[i]), 1'(i % 2));
			above = (sweep[i] == 63) ? 6'd63 : 6'(sweep[i] + 1);
			send_column(make_column("G", "T", 6'(sweep[i]), above, 1));
		end
	endtask

	// one long alignment streamed back to back, then a short one to see the clear
	task automatic test_long_alignment();
		int i;
		configure(0, 1);
		idling_on = 1'b0;
		for (i = 0; i < LONG_COLUMNS; i++)
			send_column(make_column("A", "C", 6'($urandom_range(63, 1)),
				6'($urandom_range(63, 1)), i == LONG_COLUMNS - 1));
		send_column(make_column("C", "C", 10, 20, 0));
		send_column(make_column("C", "A", 33, 5, 1));
		drain_scores();
		idling_on = 1'b1;
	endtask

	task automatic test_random_alignments();
		int phase, sent, n, i;
		logic [5:0] thr;
		column_t c;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: thr = 0;
				1: thr = 6'($urandom_range(20, 1));
				2: thr = 6'($urandom_range(30));
				3: thr = 45;
				4: thr = 6'($urandom_range(63));
				default: thr = 12;
			endcase
			configure(thr, (phase == 0) ? 1'b0 : 1'($urandom_range(1)));
			// a long stretch with no idling on either side
			idling_on = (phase != 2);
			sent = 0;
			while (sent < PHASE_COLUMNS) begin
				n = ($urandom_range(99) < 90) ? $urandom_range(24, 1) : $urandom_range(120, 25);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(99) < 10) begin
						// noise column, any field value
						c = make_column(8'($urandom_range(255)), 8'($urandom_range(255)),
							6'($urandom_range(63)), 6'($urandom_range(63)), 0);
					end else begin
						c.b1 = random_base();
						c.b2 = ($urandom_range(99) < 60) ? c.b1 : random_base();
						c.q1 = random_quality();
						c.q2 = random_quality();
					end
					c.last = (i == n - 1);
					send_column(c);
				end
				sent += n;
			end
		end
		idling_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_columns();
		test_threshold_sweep();
		test_long_alignment();
		test_random_alignments();
		drain_scores();
		if (fail_count == 0)
			$display("PASS alignment_mismatch_scorer_unit");
		else
			$display("FAIL alignment_mismatch_scorer_unit");
		$finish;
	end

endmodule
